// ----- hw/rtl/tgad_pkg.sv -----
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types and constants for the truecolor TGA byte-stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tgad_pkg;

	localparam int unsigned SHIFT_W  = 5;
	localparam int unsigned CFG_IDX_W = 2;

	// Header byte offsets
	localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
	localparam logic [4:0] HDR_DEPTH      = 5'd16;
	localparam logic [4:0] HDR_LAST       = 5'd17;

	localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] DEPTH_24       = 8'd24;
	localparam logic [7:0] DEPTH_32       = 8'd32;
	localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;

	typedef enum logic [1:0] {
		KIND_PIXEL     = 2'd0,
		KIND_HEADER    = 2'd1,
		KIND_BAD_TYPE  = 2'd2,
		KIND_BAD_DEPTH = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PIXELS = 2'd1,
		PH_IDLE   = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA_SHIFT = 2'd0,
		CFG_RED_SHIFT   = 2'd1,
		CFG_GREEN_SHIFT = 2'd2,
		CFG_BLUE_SHIFT  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] alpha;
		logic [SHIFT_W-1:0] red;
		logic [SHIFT_W-1:0] green;
		logic [SHIFT_W-1:0] blue;
	} shift_cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] pixel_word;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        is_last;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tgad_if.sv -----
// ----------------------------------------------------------------------------
// tgad_if
// Valid/ready channels: file bytes in, decoded results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tgad_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source (output valid, output data_byte, output start_of_file, input ready);
	modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tgad_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [31:0] pixel_word;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        is_last;

	modport source (output valid, output result_kind, output pixel_word,
		output image_width, output image_height, output is_last, input ready);
	modport sink   (input valid, input result_kind, input pixel_word,
		input image_width, input image_height, input is_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tgad_pack.sv -----
// ----------------------------------------------------------------------------
// tgad_pack
// Places the four channel bytes of a pixel at their configured bit positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgad_pack (
	input  tgad_pkg::shift_cfg_t shifts,
	input  logic [7:0]           alpha,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output logic [31:0]          word
);
	import tgad_pkg::*;

	// bits pushed past bit 31 fall off
	assign word = ({24'd0, alpha} << shifts.alpha) | ({24'd0, red} << shifts.red) |
		({24'd0, green} << shifts.green) | ({24'd0, blue} << shifts.blue);

endmodule

`default_nettype wire

// ----- hw/rtl/tgad_parse.sv -----
// ----------------------------------------------------------------------------
// tgad_parse
// Header/pixel parse state, one byte per cycle unless stalled, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgad_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  tgad_pkg::item_t      item_s1,
	input  tgad_pkg::shift_cfg_t shifts,
	output logic                 take,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tgad_pkg::result_t    result
);
	import tgad_pkg::*;

	phase_t      phase_q, phase_d;
	logic [4:0]  idx_q, idx_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        depth32_q, depth32_d;
	logic [1:0]  bip_q, bip_d;
	logic [23:0] hold_q, hold_d;
	logic [31:0] pixels_q, pixels_d;

	phase_t      cur_phase;
	logic [4:0]  cur_idx;
	logic [1:0]  cur_bip;
	logic [23:0] cur_hold;
	logic [23:0] new_hold;
	logic [7:0]  b;
	logic        sof;
	logic        emit;
	logic        empty;
	logic        pix_done;
	logic [7:0]  pix_alpha;
	logic [31:0] packed_word;
	result_t     res_d;
	logic        out_valid_q;
	result_t     result_q;

	assign b    = item_s1.data_byte;
	assign sof  = item_s1.start_of_file;
	assign take = valid_s1 && (!out_valid_q || out_ready);

	assign empty     = (width_q == 16'd0) || (height_q == 16'd0);
	assign cur_phase = sof ? PH_HEADER : phase_q;
	assign cur_idx   = sof ? 5'd0 : idx_q;
	assign cur_bip   = sof ? 2'd0 : bip_q;
	assign cur_hold  = sof ? 24'd0 : hold_q;

	always_comb begin
		new_hold = cur_hold;
		unique case (cur_bip)
			2'd0: new_hold[7:0]   = cur_hold[7:0]   | b;
			2'd1: new_hold[15:8]  = cur_hold[15:8]  | b;
			2'd2: new_hold[23:16] = cur_hold[23:16] | b;
			2'd3: new_hold = cur_hold;
		endcase
	end

	assign pix_done  = depth32_q ? (cur_bip == 2'd3) : (cur_bip >= 2'd2);
	assign pix_alpha = depth32_q ? b : ALPHA_OPAQUE;

	tgad_pack u_pack (
		.shifts (shifts),
		.alpha  (pix_alpha),
		.red    (new_hold[23:16]),
		.green  (new_hold[15:8]),
		.blue   (new_hold[7:0]),
		.word   (packed_word)
	);

	always_comb begin
		phase_d   = cur_phase;
		idx_d     = cur_idx;
		bip_d     = cur_bip;
		hold_d    = cur_hold;
		width_d   = width_q;
		height_d  = height_q;
		depth32_d = depth32_q;
		pixels_d  = pixels_q;
		emit      = 1'b0;
		res_d     = '0;
		unique case (cur_phase)
			PH_HEADER: begin
				idx_d = cur_idx + 5'd1;
				unique case (cur_idx)
					HDR_IMAGE_TYPE: begin
						if (b != TYPE_TRUECOLOR) begin
							phase_d    = PH_IDLE;
							emit       = 1'b1;
							res_d.kind = KIND_BAD_TYPE;
						end
					end
					HDR_WIDTH_LO:  width_d[7:0]   = b;
					HDR_WIDTH_HI:  width_d[15:8]  = b;
					HDR_HEIGHT_LO: height_d[7:0]  = b;
					HDR_HEIGHT_HI: height_d[15:8] = b;
					HDR_DEPTH: begin
						if (b == DEPTH_32) begin
							depth32_d = 1'b1;
						end else if (b == DEPTH_24) begin
							depth32_d = 1'b0;
						end else begin
							phase_d    = PH_IDLE;
							emit       = 1'b1;
							res_d.kind = KIND_BAD_DEPTH;
						end
					end
					HDR_LAST: begin
						pixels_d           = 32'(width_q) * 32'(height_q);
						bip_d              = 2'd0;
						hold_d             = 24'd0;
						phase_d            = empty ? PH_IDLE : PH_PIXELS;
						emit               = 1'b1;
						res_d.kind         = KIND_HEADER;
						res_d.image_width  = width_q;
						res_d.image_height = height_q;
						res_d.is_last      = empty;
					end
					default: ;
				endcase
			end
			PH_PIXELS: begin
				if (!pix_done) begin
					bip_d  = cur_bip + 2'd1;
					hold_d = new_hold;
				end else begin
					bip_d            = 2'd0;
					hold_d           = 24'd0;
					pixels_d         = pixels_q - 32'd1;
					emit             = 1'b1;
					res_d.kind       = KIND_PIXEL;
					res_d.pixel_word = packed_word;
					res_d.is_last    = (pixels_q == 32'd1);
					if (pixels_q == 32'd1) begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			idx_q       <= 5'd0;
			width_q     <= 16'd0;
			height_q    <= 16'd0;
			depth32_q   <= 1'b0;
			bip_q       <= 2'd0;
			hold_q      <= 24'd0;
			pixels_q    <= 32'd0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_d;
			idx_q       <= idx_d;
			width_q     <= width_d;
			height_q    <= height_d;
			depth32_q   <= depth32_d;
			bip_q       <= bip_d;
			hold_q      <= hold_d;
			pixels_q    <= pixels_d;
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			result_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tgad_in_stage.sv -----
// ----------------------------------------------------------------------------
// tgad_in_stage
// Input register for file bytes; refills in the cycle the parser drains it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgad_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tgad_pkg::item_t in_item,
	input  logic            take,
	output logic            valid_s1,
	output tgad_pkg::item_t item_s1
);
	import tgad_pkg::*;

	logic    valid_q;
	item_t   item_q;

	assign in_ready = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= in_item;
		end
	end

	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tga_truecolor_pixel_decoder_core.sv -----
// ----------------------------------------------------------------------------
// tga_truecolor_pixel_decoder_core
// Uncompressed truecolor TGA decoder: checks the 18-byte header and packs
// each B,G,R(,A) pixel into a 32-bit word at programmable channel shifts.
// ----------------------------------------------------------------------------
//
//  channel    dir  beat payload
//  ---------  ---  -------------------------------------------------------
//  file_data  in   data_byte[7:0], start_of_file
//  decoded    out  result_kind[1:0], pixel_word[31:0], image_width[15:0],
//                  image_height[15:0], is_last
//  cfg_*      in   cfg_write_en, cfg_index[1:0], cfg_data[4:0] (no handshake)
//
// One byte per cycle sustained while results are taken; each byte passes the
// input register, then one pass through the parser into the result register.
// Async active-low reset: parse restarts at header byte 0, shifts return to
// A=24, R=16, G=8, B=0.
// A result beat not yet taken holds the result register; the input register
// then fills and file_data.ready drops until decoded.ready returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tga_truecolor_pixel_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	tgad_byte_if.sink                       file_data,
	tgad_result_if.source                   decoded,
	input  logic                            cfg_write_en,
	input  logic [tgad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgad_pkg::SHIFT_W-1:0]    cfg_data
);
	import tgad_pkg::*;

	shift_cfg_t shifts_q;
	item_t      in_item;
	item_t      item_s1;
	logic       valid_s1;
	logic       take;
	result_t    result;

	// Channel shifts; the user writes them only while no byte is in flight,
	// unchecked here. A change mid-image applies from the next packed pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shifts_q.alpha <= SHIFT_W'(24);
			shifts_q.red   <= SHIFT_W'(16);
			shifts_q.green <= SHIFT_W'(8);
			shifts_q.blue  <= SHIFT_W'(0);
		end else if (cfg_write_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ALPHA_SHIFT: shifts_q.alpha <= cfg_data;
				CFG_RED_SHIFT:   shifts_q.red   <= cfg_data;
				CFG_GREEN_SHIFT: shifts_q.green <= cfg_data;
				CFG_BLUE_SHIFT:  shifts_q.blue  <= cfg_data;
			endcase
		end
	end

	assign in_item.data_byte     = file_data.data_byte;
	assign in_item.start_of_file = file_data.start_of_file;

	tgad_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (file_data.valid),
		.in_ready (file_data.ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Parser advances whenever the result register is free or being drained;
	// this gates bytes that give no result as well.
	tgad_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.shifts    (shifts_q),
		.take      (take),
		.out_valid (decoded.valid),
		.out_ready (decoded.ready),
		.result    (result)
	);

	assign decoded.result_kind  = result.kind;
	assign decoded.pixel_word   = result.pixel_word;
	assign decoded.image_width  = result.image_width;
	assign decoded.image_height = result.image_height;
	assign decoded.is_last      = result.is_last;

endmodule

`default_nettype wire

// ----- hw/rtl/tgad_checker.sv -----
// ----------------------------------------------------------------------------
// tgad_checker
// Port-level checks on the decoded result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [31:0] pixel_word,
	input logic [15:0] image_width,
	input logic [15:0] image_height,
	input logic        is_last
);
	import tgad_pkg::*;

	// last flag only on pixels or on the header of an empty image
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |->
			(result_kind == KIND_PIXEL) || (result_kind == KIND_HEADER))
		else $error("is_last on an error result");

	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != KIND_PIXEL) |-> (pixel_word == 32'd0))
		else $error("pixel_word nonzero on a non-pixel result");

	a_dims_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != KIND_HEADER) |->
			(image_width == 16'd0) && (image_height == 16'd0))
		else $error("dimensions nonzero outside a header result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
			$stable(pixel_word) && $stable(is_last))
		else $error("stalled result beat changed");

endmodule

bind tga_truecolor_pixel_decoder_core tgad_checker u_tgad_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (decoded.valid),
	.out_ready    (decoded.ready),
	.result_kind  (decoded.result_kind),
	.pixel_word   (decoded.pixel_word),
	.image_width  (decoded.image_width),
	.image_height (decoded.image_height),
	.is_last      (decoded.is_last)
);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the truecolor TGA decoder: streams headers and pixel
// data through the byte channel and compares each decoded beat against an
// in-bench copy of the parser, under several shift settings and idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	import tgad_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_BYTES   = 290;
	localparam int SETTLE_CYCLES = 6;   // input and result registers plus margin
	localparam int NUM_PHASES    = 6;

	// ------------------------------------------------------------------------
	// Tracks the parse state and holds the decoded beats still due.
	// ------------------------------------------------------------------------
	class tga_decode_tracker;
		shift_cfg_t  shifts;
		phase_t      phase;
		logic [4:0]  hdr_pos;
		logic [15:0] width_q;
		logic [15:0] height_q;
		logic        deep;
		logic [1:0]  pix_pos;
		logic [23:0] chan;
		logic [31:0] left;
		result_t     due_results[$];
		int          errors;
		int          checked;
		int          pixel_cnt;
		int          header_cnt;
		int          reject_cnt;

		function new();
			shifts   = '{alpha: 5'd24, red: 5'd16, green: 5'd8, blue: 5'd0};
			phase    = PH_HEADER;
			hdr_pos  = '0;
			width_q  = '0;
			height_q = '0;
			deep     = 1'b0;
			pix_pos  = '0;
			chan     = '0;
			left     = '0;
			errors   = 0;
			checked  = 0;
			pixel_cnt  = 0;
			header_cnt = 0;
			reject_cnt = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [4:0] v);
			case (idx)
				CFG_ALPHA_SHIFT: shifts.alpha = v;
				CFG_RED_SHIFT:   shifts.red   = v;
				CFG_GREEN_SHIFT: shifts.green = v;
				CFG_BLUE_SHIFT:  shifts.blue  = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void push(kind_t k, logic [31:0] w, logic [15:0] wd, logic [15:0] ht,
				logic l);
			result_t r;
			r.kind         = k;
			r.pixel_word   = w;
			r.image_width  = wd;
			r.image_height = ht;
			r.is_last      = l;
			due_results.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b, logic sof);
			logic [4:0]  idx;
			logic [1:0]  pos;
			int          need;
			logic [7:0]  a;
			logic [31:0] word;
			if (sof) begin
				phase   = PH_HEADER;
				hdr_pos = '0;
				pix_pos = '0;
				chan    = '0;
			end
			if (phase == PH_HEADER) begin
				idx     = hdr_pos;
				hdr_pos = hdr_pos + 5'd1;
				case (idx)
					HDR_IMAGE_TYPE: begin
						if (b != TYPE_TRUECOLOR) begin
							phase = PH_IDLE;
							push(KIND_BAD_TYPE, '0, '0, '0, 1'b0);
						end
					end
					HDR_WIDTH_LO:  width_q[7:0]   = b;
					HDR_WIDTH_HI:  width_q[15:8]  = b;
					HDR_HEIGHT_LO: height_q[7:0]  = b;
					HDR_HEIGHT_HI: height_q[15:8] = b;
					HDR_DEPTH: begin
						if (b == DEPTH_32) deep = 1'b1;
						else if (b == DEPTH_24) deep = 1'b0;
						else begin
							phase = PH_IDLE;
							push(KIND_BAD_DEPTH, '0, '0, '0, 1'b0);
						end
					end
					HDR_LAST: begin
						left    = 32'(width_q) * 32'(height_q);
						pix_pos = '0;
						chan    = '0;
						phase   = (left == 0) ? PH_IDLE : PH_PIXELS;
						push(KIND_HEADER, '0, width_q, height_q, left == 0);
					end
					default: ;
				endcase
			end else if (phase == PH_PIXELS) begin
				need = deep ? 4 : 3;
				pos  = pix_pos;
				if (pos < 2'd3) chan = chan | (24'(b) << (8 * pos));
				if (int'(pos) + 1 < need) begin
					pix_pos = pos + 2'd1;
				end else begin
					a    = deep ? b : ALPHA_OPAQUE;
					word = (32'(a) << shifts.alpha) | (32'(chan[23:16]) << shifts.red) |
						(32'(chan[15:8]) << shifts.green) | (32'(chan[7:0]) << shifts.blue);
					pix_pos = '0;
					chan    = '0;
					left    = left - 32'd1;
					if (left == 0) phase = PH_IDLE;
					push(KIND_PIXEL, word, '0, '0, left == 0);
				end
			end
		endfunction

		function bit field_ok(string name, logic [31:0] exp, logic [31:0] act);
			if (exp !== act)
				$display("%0t: result %0d %s mismatch: expected %0h actual %0h",
					$time, checked, name, exp, act);
			return exp === act;
		endfunction

		function void match_result(logic [1:0] kind, logic [31:0] word, logic [15:0] wd,
				logic [15:0] ht, logic last);
			result_t exp;
			bit      ok;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: expected none actual kind %0d word %0h",
					$time, kind, word);
				errors++;
				return;
			end
			exp = due_results.pop_front();
			ok  = field_ok("result_kind", 32'(exp.kind), 32'(kind));
			ok &= field_ok("pixel_word", exp.pixel_word, word);
			ok &= field_ok("image_width", 32'(exp.image_width), 32'(wd));
			ok &= field_ok("image_height", 32'(exp.image_height), 32'(ht));
			ok &= field_ok("is_last", 32'(exp.is_last), 32'(last));
			if (!ok) errors++;
			case (exp.kind)
				KIND_PIXEL:  pixel_cnt++;
				KIND_HEADER: header_cnt++;
				default:     reject_cnt++;
			endcase
			checked++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SHIFT_W-1:0]   cfg_data;

	tgad_byte_if   file_bus ();
	tgad_result_if res_bus ();

	tga_decode_tracker tracker;

	int src_idle;      // percent of cycles the byte source holds off
	int sink_idle;     // percent of cycles the result sink stalls
	int bytes_sent;
	int files_sent;
	int cycle_count;

	tga_truecolor_pixel_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.file_data    (file_bus),
		.decoded      (res_bus),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Result side: check what was taken at this edge, then pick the next ready.
	// Values read here are the ones present at the edge, since all drives are NBAs.
	always @(posedge clk) begin
		if (res_bus.valid && res_bus.ready)
			tracker.match_result(res_bus.result_kind, res_bus.pixel_word,
				res_bus.image_width, res_bus.image_height, res_bus.is_last);
		res_bus.ready <= arst_n && ($urandom_range(99) >= sink_idle);
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped by watchdog after %0d cycles", cycle_count);
		$display("FAILED: results differ");
		$finish;
	end

	// One byte beat. Returns just after the accepting edge, valid still high so
	// back-to-back beats never toggle valid within a step.
	task automatic send_beat(input logic [7:0] d, input logic s);
		while ($urandom_range(99) < src_idle) begin
			file_bus.valid <= 1'b0;
			@(posedge clk);
		end
		file_bus.valid         <= 1'b1;
		file_bus.data_byte     <= d;
		file_bus.start_of_file <= s;
		@(posedge clk);
		while (!file_bus.ready) @(posedge clk);
		tracker.take_byte(d, s);
		bytes_sent++;
	endtask

	// First 'count' bytes of an 18-byte header; unchecked fields get random filler.
	task automatic send_header(input logic first_sof, input logic [7:0] img_type,
			input logic [15:0] w, input logic [15:0] h, input logic [7:0] depth,
			input int count);
		logic [7:0] v;
		files_sent++;
		for (int i = 0; i < count; i++) begin
			v = 8'($urandom_range(255));
			case (5'(i))
				HDR_IMAGE_TYPE: v = img_type;
				HDR_WIDTH_LO:   v = w[7:0];
				HDR_WIDTH_HI:   v = w[15:8];
				HDR_HEIGHT_LO:  v = h[7:0];
				HDR_HEIGHT_HI:  v = h[15:8];
				HDR_DEPTH:      v = depth;
				default: ;
			endcase
			send_beat(v, (i == 0) ? first_sof : 1'b0);
		end
	endtask

	// Random file. Mostly well-formed small images; the rest are empty images,
	// rejected headers, files cut short (next file restarts them) and trailing
	// junk that the idle parser should swallow.
	task automatic send_file();
		int          pick;
		int          nbytes;
		int          tail;
		logic        deep;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  v;
		pick = $urandom_range(99);
		deep = 1'($urandom_range(1));
		w    = 16'($urandom_range(3, 1));
		h    = 16'($urandom_range(3, 1));
		if (pick < 8) begin
			// empty image, one dimension anywhere in its range
			if ($urandom_range(1)) begin
				w = 16'($urandom_range(65535));
				h = '0;
			end else begin
				w = '0;
				h = 16'($urandom_range(65535));
			end
		end
		nbytes = int'(w) * int'(h) * (deep ? 4 : 3);
		if (pick >= 8 && pick < 15) begin
			do v = 8'($urandom_range(255)); while (v == TYPE_TRUECOLOR);
			send_header(1'b1, v, w, h, DEPTH_24, 3 + $urandom_range(2));
		end else if (pick >= 15 && pick < 22) begin
			do v = 8'($urandom_range(255)); while (v == DEPTH_24 || v == DEPTH_32);
			send_header(1'b1, TYPE_TRUECOLOR, w, h, v, 17 + $urandom_range(1));
		end else if (pick >= 22 && pick < 26) begin
			send_header(1'b1, TYPE_TRUECOLOR, w, h, deep ? DEPTH_32 : DEPTH_24,
				$urandom_range(17, 1));
		end else begin
			send_header(1'b1, TYPE_TRUECOLOR, w, h, deep ? DEPTH_32 : DEPTH_24, 18);
			if (pick < 34 && nbytes > 0) nbytes = $urandom_range(nbytes - 1);
			tail = (pick >= 90) ? $urandom_range(4, 1) : 0;
			repeat (nbytes + tail) send_beat(8'($urandom_range(255)), 1'b0);
		end
	endtask

	// Quiesce: source idle, every due beat in, then let the pipe empty of
	// bytes that produce nothing (mid-header or mid-pixel).
	task automatic drain();
		file_bus.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_shifts(input logic [4:0] a, input logic [4:0] r,
			input logic [4:0] g, input logic [4:0] bl);
		cfg_index_t order [4];
		logic [4:0] vals [4];
		order = '{CFG_ALPHA_SHIFT, CFG_RED_SHIFT, CFG_GREEN_SHIFT, CFG_BLUE_SHIFT};
		vals  = '{a, r, g, bl};
		for (int i = 0; i < 4; i++) begin
			cfg_write_en <= 1'b1;
			cfg_index    <= order[i];
			cfg_data     <= vals[i];
			@(posedge clk);
			tracker.set_reg(order[i], vals[i]);
		end
		cfg_write_en <= 1'b0;
	endtask

	initial begin
		logic [4:0] sa;
		logic [4:0] sr;
		logic [4:0] sg;
		logic [4:0] sb;
		int         phase_start;

		tracker    = new();
		src_idle   = 16;
		sink_idle  = 46;
		bytes_sent = 0;
		files_sent = 0;

		arst_n                 <= 1'b0;
		cfg_write_en           <= 1'b0;
		cfg_index              <= CFG_ALPHA_SHIFT;
		cfg_data               <= '0;
		file_bus.valid         <= 1'b0;
		file_bus.data_byte     <= '0;
		file_bus.start_of_file <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed, reset shifts ---
		// Straight after reset, no start flag: parsed as a header from byte 0.
		// 24-bit 1x1 image, pixel with all-ones, all-zero and mid-scale channels.
		send_header(1'b0, TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 18);
		send_beat(8'hff, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'hff, 1'b0);   // after the last pixel: ignored
		// Run-length type: rejected on the type byte.
		send_header(1'b1, 8'd10, 16'd0, 16'd0, DEPTH_24, 3);
		// 16-bit depth: rejected on the depth byte.
		send_header(1'b1, TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd16, 17);
		// Empty image, max width: header beat carries is_last.
		send_header(1'b1, TYPE_TRUECOLOR, 16'hffff, 16'h0000, DEPTH_32, 18);
		// 32-bit 1x1 with real alpha.
		send_header(1'b1, TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_32, 18);
		send_beat(8'h00, 1'b0);
		send_beat(8'hff, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'hff, 1'b0);

		// --- random phases ---
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph / 2)
				0: begin src_idle = 16; sink_idle = 46; end
				1: begin src_idle = 46; sink_idle = 16; end
				default: begin src_idle = 0; sink_idle = 0; end
			endcase
			case (ph)
				0: begin sa = 5'd24; sr = 5'd16; sg = 5'd8;  sb = 5'd0;  end
				1: begin sa = 5'd0;  sr = 5'd8;  sg = 5'd16; sb = 5'd24; end
				2: begin sa = 5'd0;  sr = 5'd0;  sg = 5'd0;  sb = 5'd0;  end
				3: begin sa = 5'd24; sr = 5'd24; sg = 5'd24; sb = 5'd24; end
				default: begin
					sa = 5'($urandom_range(24));
					sr = 5'($urandom_range(24));
					sg = 5'($urandom_range(24));
					sb = 5'($urandom_range(24));
				end
			endcase
			// Leave a 32-bit 3x1 image half done across the shift change:
			// first pixel packs with the old shifts, the rest with the new.
			if (ph > 0) begin
				send_header(1'b1, TYPE_TRUECOLOR, 16'd3, 16'd1, DEPTH_32, 18);
				repeat (6) send_beat(8'($urandom_range(255)), 1'b0);
			end
			drain();
			write_shifts(sa, sr, sg, sb);
			if (ph > 0) repeat (6) send_beat(8'($urandom_range(255)), 1'b0);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) send_file();
		end

		drain();
		$display("Streamed %0d bytes in %0d files over %0d shift settings and three idle mixes.",
			bytes_sent, files_sent, NUM_PHASES);
		$display("Checked %0d beats: %0d headers, %0d rejected headers, %0d pixels.",
			tracker.checked, tracker.header_cnt, tracker.reject_cnt, tracker.pixel_cnt);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tgad_pkg.sv
hw/rtl/tgad_if.sv
hw/rtl/tgad_pack.sv
hw/rtl/tgad_parse.sv
hw/rtl/tgad_in_stage.sv
hw/rtl/tga_truecolor_pixel_decoder_core.sv
hw/rtl/tgad_checker.sv
tb/tb.sv
